/* src/csa64_pkg.sv */
// Package for the checked signed 64-bit ALU: operation codes, constants
// and the stage record types. It has no dependencies.
package csa64_pkg;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_REM = 3'd4;

  localparam logic [63:0] S64_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MIN  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam int DIV_STEPS = 64;

  // Front stage: checked sum or difference, magnitudes, partial products.
  typedef struct packed {
    logic [2:0]  op;
    logic        sa;
    logic        sb;
    logic        err;
    logic        nz;     // both magnitudes nonzero
    logic [63:0] res;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] ll;
    logic [63:0] lh;
    logic [63:0] hl;
    logic [63:0] hh;
  } front_t;

  // Divider stage: restoring division, one quotient bit per stage.
  typedef struct packed {
    logic [2:0]  op;
    logic        sa;
    logic        sb;
    logic        err;
    logic [63:0] res;
    logic [63:0] rem;
    logic [63:0] quo;
    logic [63:0] mb;
  } div_t;

endpackage

/* src/checked_signed_alu_64_unit.sv */
// Top level of the checked signed 64-bit ALU, a single deep pipeline.
// Depends on csa64_pkg for codes, constants and stage records.
//
//  channel | handshake            | fields
//  input   | in_valid, in_stall   | operation, operand_a, operand_b
//  output  | out_valid, out_stall | value, error
//
// One item enters per cycle while the pipeline is not held. Each item passes
// 68 register stages: input, front, product, the 64 restoring-divider stages
// that every item goes through, and output. Reset clears only the valid bits.
// The whole pipeline holds while a valid result is stalled, so in_stall
// follows out_valid and out_stall.
module checked_signed_alu_64_unit
  import csa64_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         operation,
  input  logic signed [63:0] operand_a,
  input  logic signed [63:0] operand_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] value,
  output logic               error
);

  logic advance;
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  // Input register.
  logic        s1_valid;
  logic [2:0]  s1_op;
  logic [63:0] s1_a;
  logic [63:0] s1_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
    end
    if (advance) begin
      s1_op <= operation;
      s1_a  <= operand_a;
      s1_b  <= operand_b;
    end
  end

  // Front stage.
  front_t      s2_next;
  front_t      s2;
  logic        s2_valid;
  logic [63:0] sum;
  logic [63:0] diff;

  always_comb begin
    s2_next     = '0;
    s2_next.op  = s1_op;
    s2_next.sa  = s1_a[63];
    s2_next.sb  = s1_b[63];
    s2_next.ma  = s1_a[63] ? (64'd0 - s1_a) : s1_a;
    s2_next.mb  = s1_b[63] ? (64'd0 - s1_b) : s1_b;
    s2_next.nz  = (s1_a != 64'd0) && (s1_b != 64'd0);
    sum         = s1_a + s1_b;
    diff        = s1_a - s1_b;
    s2_next.ll  = 64'(s2_next.ma[31:0])  * 64'(s2_next.mb[31:0]);
    s2_next.lh  = 64'(s2_next.ma[31:0])  * 64'(s2_next.mb[63:32]);
    s2_next.hl  = 64'(s2_next.ma[63:32]) * 64'(s2_next.mb[31:0]);
    s2_next.hh  = 64'(s2_next.ma[63:32]) * 64'(s2_next.mb[63:32]);
    unique case (s1_op) inside
      OP_ADD: begin
        s2_next.res = sum;
        s2_next.err = (s1_a[63] == s1_b[63]) && (sum[63] != s1_a[63]);
      end
      OP_SUB: begin
        s2_next.res = diff;
        s2_next.err = (s1_a[63] != s1_b[63]) && (diff[63] != s1_a[63]);
      end
      OP_MUL: begin
        s2_next.err = 1'b0;
      end
      OP_DIV, OP_REM: begin
        s2_next.err = (s1_b == 64'd0) || ((s1_a == S64_MIN) && (s1_b == ALL_ONES));
      end
      default: begin
        s2_next.err = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
    if (advance) begin
      s2 <= s2_next;
    end
  end

  // Product assembly and range check; this feeds the divider chain.
  div_t        d_next [0:DIV_STEPS];
  div_t        d      [0:DIV_STEPS];
  logic        d_valid [0:DIV_STEPS];
  logic [63:0] mid;
  logic [63:0] p_hi;
  logic [63:0] p_lo;
  logic        p_neg;

  always_comb begin
    mid   = {32'd0, s2.ll[63:32]} + {32'd0, s2.lh[31:0]} + {32'd0, s2.hl[31:0]};
    p_lo  = {mid[31:0], s2.ll[31:0]};
    p_hi  = s2.hh + {32'd0, s2.lh[63:32]} + {32'd0, s2.hl[63:32]} + {32'd0, mid[63:32]};
    p_neg = (s2.sa != s2.sb) && s2.nz;
    d_next[0]     = '0;
    d_next[0].op  = s2.op;
    d_next[0].sa  = s2.sa;
    d_next[0].sb  = s2.sb;
    d_next[0].err = s2.err;
    d_next[0].res = s2.res;
    d_next[0].quo = s2.ma;
    d_next[0].mb  = s2.mb;
    if (s2.op == OP_MUL) begin
      d_next[0].err = (p_hi != 64'd0) ||
                      (p_neg ? (p_lo > S64_MIN) : (p_lo >= S64_MIN));
      d_next[0].res = p_neg ? (64'd0 - p_lo) : p_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid[0] <= 1'b0;
    end else if (advance) begin
      d_valid[0] <= s2_valid;
    end
    if (advance) begin
      d[0] <= d_next[0];
    end
  end

  // Each stage shifts one dividend bit into the partial remainder and
  // subtracts the divisor when it fits, yielding one quotient bit.
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    logic [64:0] trial;
    logic        fits;

    always_comb begin
      trial           = {d[i].rem, d[i].quo[63]};
      fits            = trial >= {1'b0, d[i].mb};
      d_next[i+1]     = d[i];
      d_next[i+1].rem = fits ? 64'(trial - {1'b0, d[i].mb}) : trial[63:0];
      d_next[i+1].quo = {d[i].quo[62:0], fits};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        d_valid[i+1] <= 1'b0;
      end else if (advance) begin
        d_valid[i+1] <= d_valid[i];
      end
      if (advance) begin
        d[i+1] <= d_next[i+1];
      end
    end
  end

  // Output register.
  div_t        last;
  logic [63:0] value_next;

  assign last = d[DIV_STEPS];

  always_comb begin
    if (last.err) begin
      value_next = ALL_ONES;
    end else if (last.op == OP_DIV) begin
      value_next = (last.sa != last.sb) ? (64'd0 - last.quo) : last.quo;
    end else if (last.op == OP_REM) begin
      value_next = last.sa ? (64'd0 - last.rem) : last.rem;
    end else begin
      value_next = last.res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= d_valid[DIV_STEPS];
    end
    if (advance) begin
      value <= value_next;
      error <= last.err;
    end
  end

  a_error_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> value == ALL_ONES)
    else $error("error result without all-ones value");

  a_div_zero: assert property (@(posedge clk) disable iff (rst)
    d_valid[0] && (d[0].op == OP_DIV || d[0].op == OP_REM) && d[0].mb == 64'd0
      |-> d[0].err)
    else $error("division by zero not flagged");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(d_valid[DIV_STEPS]) && $stable(last))
    else $error("divider chain moved during a stall");

endmodule
